FILE: hdl/rpl_pkg.sv
`default_nettype none

package rpl_pkg;

    // Column geometry
    localparam int FRAMES    = 16;
    localparam int LEDS      = 8;
    localparam int FRAME_W   = 4;
    localparam int LED_W     = 3;
    localparam int WORD_W    = 16;
    localparam int LEVEL_W   = 5;
    localparam int PAUSE_W   = 16;
    localparam int COLOR_W   = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    // Pixel word layout: red 15:11, green 10:6, blue 4:0
    localparam int RED_LSB   = 11;
    localparam int GREEN_LSB = 6;
    localparam int BLUE_LSB  = 0;

    // Register reset values
    localparam logic [FRAME_W-1:0] LAST_FRAME_RST  = FRAME_W'(9);
    localparam logic [PAUSE_W-1:0] PAUSE_TICKS_RST = PAUSE_W'(750);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LAST_FRAME  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_TICKS = 1'b1;

    typedef enum logic [COLOR_W-1:0] {
        COLOR_RED   = 2'd0,
        COLOR_GREEN = 2'd1,
        COLOR_BLUE  = 2'd2
    } t_color;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    typedef logic [LEVEL_W-1:0] t_level;

    // Pick one color channel out of a pixel word
    function automatic t_level level_of(input logic [WORD_W-1:0] word, input t_color color);
        t_level lvl;
        case (color)
            COLOR_RED:   lvl = word[RED_LSB +: LEVEL_W];
            COLOR_GREEN: lvl = word[GREEN_LSB +: LEVEL_W];
            COLOR_BLUE:  lvl = word[BLUE_LSB +: LEVEL_W];
            default:     lvl = '0;
        endcase
        return lvl;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/rgb_pov_pwm_line_driver_unit.sv
`default_nettype none

// RGB POV column driver. Takes one beat per clock while the output side keeps up:
// a write beat stores one pixel word into the 16-frame store, a tick beat produces
// one LED line for the next color slot (red, green, blue in turn; duty count steps
// after blue), or a blank line while a pause runs. Two register stages: the first
// updates frame/duty/color/pause state and reads a whole frame row from the store
// on a frame latch, the second does the eight level compares into the output
// register, so a tick's line passes through both before it reaches the outputs, and
// one tick is taken every cycle while the output side keeps up. Store words have
// per-word valid bits cleared by reset, so no clearing pass is needed. Config writes
// are taken at any time (o_cfg_ready stays high) but are meant for idle periods.
module rgb_pov_pwm_line_driver_unit
    import rpl_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // config write channel
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [CFG_DAT_W-1:0] i_cfg_data,
    // input beats
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire                  i_operation,
    input  wire  [FRAME_W-1:0]   i_frame_index,
    input  wire  [LED_W-1:0]     i_led_index,
    input  wire  [WORD_W-1:0]    i_pixel_word,
    // result beats
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic [LEDS-1:0]      o_led_line,
    output logic [COLOR_W-1:0]   o_color_slot,
    output logic                 o_paused
);

    // Config registers
    logic [FRAME_W-1:0] r_last_frame;
    logic [PAUSE_W-1:0] r_pause_ticks;

    // Display state
    logic [FRAME_W-1:0] r_cur_frame, n_cur_frame;
    logic [LEVEL_W-1:0] r_duty, n_duty;
    t_color             r_color, n_color;
    logic [PAUSE_W-1:0] r_pause_left, n_pause_left;

    // Stage 1 registers
    logic               r_s1_valid;
    logic               r_s1_latch, n_latch;
    logic               r_s1_paused;
    t_color             r_s1_color;
    logic [LEVEL_W-1:0] r_s1_duty;

    // Frame store and per-word valid bits
    logic [LEDS*WORD_W-1:0] r_frame_mem [FRAMES];
    logic [LEDS-1:0]        r_word_vld  [FRAMES];
    logic [LEDS*WORD_W-1:0] r_rd_row;
    logic [LEDS-1:0]        r_rd_vld;

    // Latched levels
    t_level r_red_lvl   [LEDS];
    t_level r_green_lvl [LEDS];
    t_level r_blue_lvl  [LEDS];

    // Output register
    logic               r_out_valid;
    logic [LEDS-1:0]    r_led_line, n_led_line;
    t_color             r_out_color;
    logic               r_out_paused;

    logic in_acc, tick_acc, wr_acc, s1_adv;
    logic [FRAME_W:0] inc_frame;
    logic [LEDS*WORD_W-1:0] row_word;

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign s1_adv      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || s1_adv;
    assign in_acc      = i_in_valid && o_in_ready;
    assign tick_acc    = in_acc && (t_op'(i_operation) == OP_TICK);
    assign wr_acc      = in_acc && (t_op'(i_operation) == OP_WRITE);

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_frame  <= LAST_FRAME_RST;
            r_pause_ticks <= PAUSE_TICKS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LAST_FRAME:  r_last_frame  <= i_cfg_data[FRAME_W-1:0];
                REG_PAUSE_TICKS: r_pause_ticks <= i_cfg_data[PAUSE_W-1:0];
                default: ;
            endcase
        end
    end

    // Tick state update: pause countdown, frame advance, color rotation, duty step
    always_comb begin
        n_cur_frame  = r_cur_frame;
        n_duty       = r_duty;
        n_color      = r_color;
        n_pause_left = r_pause_left;
        n_latch      = 1'b0;
        inc_frame    = {1'b0, r_cur_frame} + (FRAME_W+1)'(1);
        if (r_pause_left != '0) begin
            n_pause_left = r_pause_left - PAUSE_W'(1);
        end else begin
            if (r_duty == '0 && r_color == COLOR_BLUE) begin
                n_latch = 1'b1;
                if (inc_frame > {1'b0, r_last_frame}) begin
                    n_cur_frame  = '0;
                    n_pause_left = r_pause_ticks;
                end else begin
                    n_cur_frame = inc_frame[FRAME_W-1:0];
                end
            end
            case (r_color)
                COLOR_RED:   n_color = COLOR_GREEN;
                COLOR_GREEN: n_color = COLOR_BLUE;
                default:     n_color = COLOR_RED;
            endcase
            if (n_color == COLOR_BLUE) begin
                n_duty = r_duty + LEVEL_W'(1);
            end
        end
    end

    // Stage 1: state and pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_frame  <= '0;
            r_duty       <= '0;
            r_color      <= COLOR_RED;
            r_pause_left <= '0;
            r_s1_valid   <= 1'b0;
            r_s1_latch   <= 1'b0;
            r_s1_paused  <= 1'b0;
            r_s1_color   <= COLOR_RED;
            r_s1_duty    <= '0;
        end else begin
            if (tick_acc) begin
                r_cur_frame  <= n_cur_frame;
                r_duty       <= n_duty;
                r_color      <= n_color;
                r_pause_left <= n_pause_left;
                r_s1_valid   <= 1'b1;
                r_s1_latch   <= n_latch;
                r_s1_paused  <= (r_pause_left != '0);
                r_s1_color   <= n_color;
                r_s1_duty    <= r_duty;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Frame store: word write, full row read on latch
    always_ff @(posedge i_clk) begin
        if (wr_acc) begin
            r_frame_mem[i_frame_index][i_led_index*WORD_W +: WORD_W] <= i_pixel_word;
        end
        if (tick_acc && n_latch) begin
            r_rd_row <= r_frame_mem[n_cur_frame];
        end
    end

    // Word valid bits; unwritten words read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < FRAMES; f++) begin
                r_word_vld[f] <= '0;
            end
            r_rd_vld <= '0;
        end else begin
            if (wr_acc) begin
                r_word_vld[i_frame_index][i_led_index] <= 1'b1;
            end
            if (tick_acc && n_latch) begin
                r_rd_vld <= r_word_vld[n_cur_frame];
            end
        end
    end

    // Level compares for the slot
    always_comb begin
        for (int i = 0; i < LEDS; i++) begin
            row_word[i*WORD_W +: WORD_W] = r_rd_vld[i] ? r_rd_row[i*WORD_W +: WORD_W] : '0;
        end
        for (int i = 0; i < LEDS; i++) begin
            t_level lvl;
            if (r_s1_latch) begin
                lvl = level_of(row_word[i*WORD_W +: WORD_W], r_s1_color);
            end else begin
                case (r_s1_color)
                    COLOR_RED:   lvl = r_red_lvl[i];
                    COLOR_GREEN: lvl = r_green_lvl[i];
                    default:     lvl = r_blue_lvl[i];
                endcase
            end
            n_led_line[i] = !r_s1_paused && (lvl > r_s1_duty);
        end
    end

    // Latched levels, loaded when a new frame comes in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEDS; i++) begin
                r_red_lvl[i]   <= '0;
                r_green_lvl[i] <= '0;
                r_blue_lvl[i]  <= '0;
            end
        end else if (s1_adv && r_s1_latch) begin
            for (int i = 0; i < LEDS; i++) begin
                r_red_lvl[i]   <= level_of(row_word[i*WORD_W +: WORD_W], COLOR_RED);
                r_green_lvl[i] <= level_of(row_word[i*WORD_W +: WORD_W], COLOR_GREEN);
                r_blue_lvl[i]  <= level_of(row_word[i*WORD_W +: WORD_W], COLOR_BLUE);
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_led_line   <= n_led_line;
            r_out_color  <= r_s1_color;
            r_out_paused <= r_s1_paused;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_led_line   = r_led_line;
    assign o_color_slot = COLOR_W'(r_out_color);
    assign o_paused     = r_out_paused;

`ifndef ASSERT_OFF
    // A blank pause beat never lights an LED
    a_pause_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_paused |-> o_led_line == '0)
        else $error("pause beat with LEDs lit");

    // A frame latch only happens on a non-pause red slot
    a_latch_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_latch |-> r_s1_color == COLOR_RED && !r_s1_paused)
        else $error("frame latch outside a red slot");

    // An empty first stage always accepts
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> o_in_ready)
        else $error("stall with empty first stage");

    // A write beat never produces a result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_acc |=> !r_s1_valid)
        else $error("write beat produced a result");
`endif

endmodule

`default_nettype wire

FILE: test/rgb_pov_pwm_line_driver_unit_test.sv
`timescale 1ns / 100ps

module rgb_pov_pwm_line_driver_unit_test
    import rpl_pkg::*;
;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 6;

    // One expected line beat
    typedef struct {
        logic [LEDS-1:0] line;
        t_color          slot;
        logic            paused;
    } t_line_beat;

    // Column state tracker: predicts the line beat of every tick and checks it
    class pov_line_board;
        logic [WORD_W-1:0]  pixels [FRAMES*LEDS];
        t_level             red_lv [LEDS];
        t_level             grn_lv [LEDS];
        t_level             blu_lv [LEDS];
        logic [FRAME_W-1:0] shown_frame;
        t_level             duty;
        t_color             slot;
        logic [PAUSE_W-1:0] blank_left;
        logic [FRAME_W-1:0] last_frame;
        logic [PAUSE_W-1:0] pause_len;
        t_line_beat         lines_due [$];
        int                 errors;

        function new();
            foreach (pixels[k]) pixels[k] = '0;
            for (int i = 0; i < LEDS; i++) begin
                red_lv[i] = '0;
                grn_lv[i] = '0;
                blu_lv[i] = '0;
            end
            shown_frame = '0;
            duty        = '0;
            slot        = COLOR_RED;
            blank_left  = '0;
            last_frame  = LAST_FRAME_RST;
            pause_len   = PAUSE_TICKS_RST;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            if (idx == REG_LAST_FRAME)
                last_frame = data[FRAME_W-1:0];
            else if (idx == REG_PAUSE_TICKS)
                pause_len = data[PAUSE_W-1:0];
        endfunction

        // Accepted input beat: store a pixel or predict one line
        function void take_beat(t_op op, logic [FRAME_W-1:0] fr, logic [LED_W-1:0] led,
                                logic [WORD_W-1:0] word);
            t_line_beat       beat;
            logic [FRAME_W:0] nxt;
            logic [WORD_W-1:0] w;
            t_level           lv;
            if (op == OP_WRITE) begin
                pixels[fr*LEDS + led] = word;
                return;
            end
            // blank tick while the pause runs
            if (blank_left != 0) begin
                blank_left    = blank_left - 1'b1;
                beat.line     = '0;
                beat.slot     = slot;
                beat.paused   = 1'b1;
                lines_due.push_back(beat);
                return;
            end
            // new PWM period: step the frame, maybe wrap and start a pause
            if (duty == 0 && slot == COLOR_BLUE) begin
                nxt = shown_frame + 1'b1;
                if (nxt > last_frame) begin
                    nxt        = '0;
                    blank_left = pause_len;
                end
                shown_frame = nxt[FRAME_W-1:0];
                for (int i = 0; i < LEDS; i++) begin
                    w         = pixels[shown_frame*LEDS + i];
                    red_lv[i] = w[15:11];
                    grn_lv[i] = w[10:6];
                    blu_lv[i] = w[4:0];
                end
            end
            case (slot)
                COLOR_RED:   slot = COLOR_GREEN;
                COLOR_GREEN: slot = COLOR_BLUE;
                default:     slot = COLOR_RED;
            endcase
            for (int i = 0; i < LEDS; i++) begin
                case (slot)
                    COLOR_RED:   lv = red_lv[i];
                    COLOR_GREEN: lv = grn_lv[i];
                    default:     lv = blu_lv[i];
                endcase
                beat.line[i] = (lv > duty);
            end
            beat.slot   = slot;
            beat.paused = 1'b0;
            if (slot == COLOR_BLUE)
                duty = duty + 1'b1;
            lines_due.push_back(beat);
        endfunction

        // Accepted result beat: compare with the oldest prediction
        function void check_line(logic [LEDS-1:0] line, logic [COLOR_W-1:0] slot_in,
                                 logic paused_in);
            t_line_beat want;
            if (lines_due.size() == 0) begin
                $display("%0t: unexpected line beat: line %h slot %0d paused %0b",
                         $time, line, slot_in, paused_in);
                errors++;
                return;
            end
            want = lines_due.pop_front();
            if (want.line !== line) begin
                $display("%0t: led_line expected %h actual %h", $time, want.line, line);
                errors++;
            end
            if (want.slot !== slot_in) begin
                $display("%0t: color_slot expected %0d actual %0d", $time, want.slot, slot_in);
                errors++;
            end
            if (want.paused !== paused_in) begin
                $display("%0t: paused expected %0b actual %0b", $time, want.paused, paused_in);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data    = '0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_ready;
    logic                 i_operation   = 1'b0;
    logic [FRAME_W-1:0]   i_frame_index = '0;
    logic [LED_W-1:0]     i_led_index   = '0;
    logic [WORD_W-1:0]    i_pixel_word  = '0;
    logic                 o_out_valid;
    logic                 i_out_ready   = 1'b0;
    logic [LEDS-1:0]      o_led_line;
    logic [COLOR_W-1:0]   o_color_slot;
    logic                 o_paused;

    pov_line_board board = new();
    bit            calm        = 1'b0;  // both sides skip idling while set
    int            hold_req    = 0;     // one long receiver hold-off, in cycles
    int            shown_last  = LAST_FRAME_RST;
    int            quiet_cycles = 0;

    rgb_pov_pwm_line_driver_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_frame_index (i_frame_index),
        .i_led_index   (i_led_index),
        .i_pixel_word  (i_pixel_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_led_line    (o_led_line),
        .o_color_slot  (o_color_slot),
        .o_paused      (o_paused)
    );

    // 20 ns clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: too long without any accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("rgb_pov_pwm_line_driver_unit_test: done, errors");
            $finish;
        end
    end

    // Offer one input beat after a random gap, return once accepted
    task automatic send_beat(input t_op op, input logic [FRAME_W-1:0] fr,
                             input logic [LED_W-1:0] led, input logic [WORD_W-1:0] word);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_frame_index <= fr;
        i_led_index   <= led;
        i_pixel_word  <= word;
        do @(posedge i_clk); while (!o_in_ready);
        board.take_beat(op, fr, led, word);
    endtask

    // Stop offering and wait for every predicted line
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.lines_due.size() != 0) @(posedge i_clk);
    endtask

    // Register write while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        drain();
        // a trailing pixel write may still be in the pipe
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    // Random mix of ticks and pixel writes; writes favor frames on display
    task automatic random_beats(input int count, input int tick_pct);
        t_op                op;
        logic [FRAME_W-1:0] fr;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 39)
                calm = ~calm;
            op = ($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_WRITE;
            fr = $urandom_range(0, 1) ? FRAME_W'($urandom_range(0, shown_last))
                                      : FRAME_W'($urandom);
            send_beat(op, fr, LED_W'($urandom), WORD_W'($urandom));
        end
        calm = 1'b0;
    endtask

    // Result side: random stalls, one long hold-off on request
    initial begin
        int gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req > 0) begin
                gap      = hold_req;
                hold_req = 0;
            end else begin
                gap = calm ? 0 : $urandom_range(0, 13);
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            board.check_line(o_led_line, o_color_slot, o_paused);
        end
    end

    // Stimulus
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pixel words at the extremes, each channel alone, unused bit 5
        send_beat(OP_WRITE, 4'd0,  3'd0, 16'hFFFF);
        send_beat(OP_WRITE, 4'd15, 3'd7, 16'hFFFF);
        send_beat(OP_WRITE, 4'd1,  3'd0, 16'hF800);
        send_beat(OP_WRITE, 4'd1,  3'd1, 16'h07C0);
        send_beat(OP_WRITE, 4'd1,  3'd2, 16'h001F);
        send_beat(OP_WRITE, 4'd1,  3'd3, 16'h0020);
        send_beat(OP_WRITE, 4'd1,  3'd7, 16'hFFDF);
        send_beat(OP_WRITE, 4'd0,  3'd7, 16'h0000);
        send_beat(OP_WRITE, 4'd9,  3'd4, 16'h0842);
        send_beat(OP_WRITE, 4'd1,  3'd5, 16'h0841);
        for (int k = 0; k < 12; k++)
            send_beat(OP_TICK, (k % 2) ? '1 : '0, (k % 2) ? '1 : '0, (k % 2) ? '1 : '0);

        // short frame loop with short pauses
        write_reg(REG_LAST_FRAME, {12'($urandom), 4'd1});
        shown_last = 1;
        write_reg(REG_PAUSE_TICKS, 16'd4);
        random_beats(60, 80);
        // result side holds off while input keeps coming
        hold_req = 90;
        random_beats(100, 80);
        drain();
        random_beats(80, 80);

        // single frame, wrap with no pause
        write_reg(REG_LAST_FRAME, {12'($urandom), 4'h0});
        shown_last = 0;
        write_reg(REG_PAUSE_TICKS, 16'd0);
        random_beats(100, 94);

        // single frame, longest pause last since it never runs out
        write_reg(REG_LAST_FRAME, {12'($urandom), 4'h0});
        shown_last = 0;
        write_reg(REG_PAUSE_TICKS, 16'hFFFF);
        random_beats(40, 85);

        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (board.errors == 0)
            $display("rgb_pov_pwm_line_driver_unit_test: done, clean");
        else
            $display("rgb_pov_pwm_line_driver_unit_test: done, errors");
        $finish;
    end

endmodule
